### sv/rmst_pkg.sv
`default_nettype none
package rmst_pkg;

    localparam int MAX_ITEMS   = 1024;
    localparam int NODE_COUNT  = 2 * MAX_ITEMS;
    localparam int POS_W       = 11;
    localparam int ADDR_W      = $clog2(NODE_COUNT);
    localparam int DATA_W      = 32;
    // path length of the deepest leaf plus one spare
    localparam int STACK_DEPTH = $clog2(MAX_ITEMS) + 1;
    localparam int STK_W       = $clog2(STACK_DEPTH + 1);

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } ram_req_t;

endpackage
`default_nettype wire

### sv/rmst_node_ram.sv
`default_nettype none
module rmst_node_ram (
    input  wire logic                        clk,
    input  wire rmst_pkg::ram_req_t          req,
    output logic [rmst_pkg::DATA_W-1:0]      rdata
);

    logic [rmst_pkg::DATA_W-1:0] mem [rmst_pkg::NODE_COUNT];

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata <= mem[req.addr];
            end
        end
    end

endmodule
`default_nettype wire

### sv/range_max_segment_tree.sv
`default_nettype none
// Range-maximum segment tree over up to 1024 signed 32-bit values, positions
// 1..size_in_use, node words held in one single-port RAM (one access per
// cycle, registered read). After reset the block sweeps every RAM word to
// zero with s_tready low. One operation is in flight at a time. With
// d = ceil(log2(size_in_use)) levels, an update steps down d levels
// recording the path, writes the leaf, then reads the sibling and writes
// the parent per level; a query descends until its range is covered or
// splits, reads the covering nodes along its boundary paths, then waits
// for the output register to be free.
// An out-of-table update leaves s_tready high, so the next beat can follow at
// once; an empty query skips the tree and loads its zero result once the
// output register is free. A finished query result waits in the output
// register while the next beat is taken.
module range_max_segment_tree (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data,   // size_in_use
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // position[10:0], new_value[42:11], range_left[53:43], range_right[64:54]
    input  wire logic [71:0] s_tdata,
    input  wire logic        s_tuser,    // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata     // max_value
);

    localparam int PW = rmst_pkg::POS_W;
    localparam int AW = rmst_pkg::ADDR_W;
    localparam int DW = rmst_pkg::DATA_W;
    localparam int SW = rmst_pkg::STK_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD_DOWN,
        S_UPD_RD,
        S_UPD_WR,
        S_Q_DOWN,
        S_Q_LWALK,
        S_Q_RWALK,
        S_Q_WAIT,
        S_Q_DONE
    } state_t;

    state_t                state_reg, state_next, ret_reg, ret_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [AW-1:0]         id_reg, id_next, rid_reg, rid_next;
    logic [PW-1:0]         lo_reg, lo_next, hi_reg, hi_next;
    logic [PW-1:0]         rlo_reg, rlo_next, rhi_reg, rhi_next;
    logic [PW-1:0]         l_reg, l_next, r_reg, r_next;
    logic [PW-1:0]         pos_reg, pos_next;
    logic [PW-1:0]         size_reg, size_next;
    logic signed [DW-1:0]  acc_reg, acc_next, val_reg, val_next;
    logic [SW-1:0]         sp_reg, sp_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [DW-1:0]         m_tdata_reg, m_tdata_next;

    logic [AW-1:0]         node_stk [rmst_pkg::STACK_DEPTH];
    logic [AW-1:0]         sib_stk  [rmst_pkg::STACK_DEPTH];
    logic                  push_en;
    logic [AW-1:0]         push_sib;
    logic [SW-1:0]         sp_top;

    rmst_pkg::ram_req_t    ram_req;
    logic [DW-1:0]         ram_rdata;
    logic signed [DW-1:0]  rd_s;

    logic [PW:0]           lohi_sum;
    logic [PW-1:0]         mid, lsize;
    logic [AW-1:0]         lc, rc;

    logic [PW-1:0]         in_pos, in_l, in_r, l_clip, r_clip;
    logic signed [DW-1:0]  in_val;

    assign in_pos = s_tdata[10:0];
    assign in_val = s_tdata[42:11];
    assign in_l   = s_tdata[53:43];
    assign in_r   = s_tdata[64:54];
    assign l_clip = (in_l == '0) ? PW'(1) : in_l;
    assign r_clip = (in_r > size_reg) ? size_reg : in_r;

    assign lohi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = lohi_sum[PW:1];
    assign lsize    = mid - lo_reg + PW'(1);
    assign lc       = id_reg + AW'(1);
    // right child sits past the whole left subtree in preorder
    assign rc       = id_reg + {lsize[AW-2:0], 1'b0};

    assign sp_top   = sp_reg - SW'(1);
    assign rd_s     = ram_rdata;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    rmst_node_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        clr_next      = clr_reg;
        id_next       = id_reg;
        rid_next      = rid_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        rlo_next      = rlo_reg;
        rhi_next      = rhi_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        pos_next      = pos_reg;
        size_next     = size_reg;
        acc_next      = acc_reg;
        val_next      = val_reg;
        sp_next       = sp_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        push_en       = 1'b0;
        push_sib      = rc;
        ram_req       = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            if (cfg_data == '0)
            begin
                size_next = PW'(1);
            end
            else if (cfg_data > PW'(rmst_pkg::MAX_ITEMS))
            begin
                size_next = PW'(rmst_pkg::MAX_ITEMS);
            end
            else
            begin
                size_next = cfg_data;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_req.en   = 1'b1;
                ram_req.we   = 1'b1;
                ram_req.addr = clr_reg;
                clr_next     = clr_reg + AW'(1);
                if (clr_reg == AW'(rmst_pkg::NODE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    id_next = AW'(1);
                    lo_next = PW'(1);
                    hi_next = size_reg;
                    sp_next = '0;
                    if (s_tuser == rmst_pkg::OP_UPDATE)
                    begin
                        pos_next = in_pos;
                        val_next = in_val;
                        if (in_pos != '0 && in_pos <= size_reg)
                        begin
                            state_next = S_UPD_DOWN;
                        end
                    end
                    else
                    begin
                        l_next = l_clip;
                        r_next = r_clip;
                        if (l_clip > r_clip)
                        begin
                            acc_next   = '0;
                            state_next = S_Q_DONE;
                        end
                        else
                        begin
                            acc_next   = {1'b1, {(DW-1){1'b0}}};
                            state_next = S_Q_DOWN;
                        end
                    end
                end
            end

            S_UPD_DOWN:
            begin
                if (lo_reg == hi_reg)
                begin
                    ram_req.en    = 1'b1;
                    ram_req.we    = 1'b1;
                    ram_req.addr  = id_reg;
                    ram_req.wdata = val_reg;
                    state_next    = (sp_reg == '0) ? S_IDLE : S_UPD_RD;
                end
                else
                begin
                    push_en = 1'b1;
                    sp_next = sp_reg + SW'(1);
                    if (pos_reg <= mid)
                    begin
                        push_sib = rc;
                        id_next  = lc;
                        hi_next  = mid;
                    end
                    else
                    begin
                        push_sib = lc;
                        id_next  = rc;
                        lo_next  = mid + PW'(1);
                    end
                end
            end

            S_UPD_RD:
            begin
                ram_req.en   = 1'b1;
                ram_req.addr = sib_stk[sp_top];
                state_next   = S_UPD_WR;
            end

            S_UPD_WR:
            begin
                ram_req.en    = 1'b1;
                ram_req.we    = 1'b1;
                ram_req.addr  = node_stk[sp_top];
                ram_req.wdata = (rd_s > val_reg) ? rd_s : val_reg;
                val_next      = (rd_s > val_reg) ? rd_s : val_reg;
                sp_next       = sp_top;
                state_next    = (sp_reg == SW'(1)) ? S_IDLE : S_UPD_RD;
            end

            S_Q_DOWN:
            begin
                if (l_reg <= lo_reg && hi_reg <= r_reg)
                begin
                    ram_req.en   = 1'b1;
                    ram_req.addr = id_reg;
                    ret_next     = S_Q_DONE;
                    state_next   = S_Q_WAIT;
                end
                else if (r_reg <= mid)
                begin
                    id_next = lc;
                    hi_next = mid;
                end
                else if (l_reg > mid)
                begin
                    id_next = rc;
                    lo_next = mid + PW'(1);
                end
                else
                begin
                    // range splits here: park the right half for later
                    rid_next   = rc;
                    rlo_next   = mid + PW'(1);
                    rhi_next   = hi_reg;
                    id_next    = lc;
                    hi_next    = mid;
                    state_next = S_Q_LWALK;
                end
            end

            S_Q_LWALK:
            begin
                if (l_reg <= lo_reg)
                begin
                    ram_req.en   = 1'b1;
                    ram_req.addr = id_reg;
                    id_next      = rid_reg;
                    lo_next      = rlo_reg;
                    hi_next      = rhi_reg;
                    ret_next     = S_Q_RWALK;
                    state_next   = S_Q_WAIT;
                end
                else if (l_reg <= mid)
                begin
                    ram_req.en   = 1'b1;
                    ram_req.addr = rc;
                    id_next      = lc;
                    hi_next      = mid;
                    ret_next     = S_Q_LWALK;
                    state_next   = S_Q_WAIT;
                end
                else
                begin
                    id_next = rc;
                    lo_next = mid + PW'(1);
                end
            end

            S_Q_RWALK:
            begin
                if (hi_reg <= r_reg)
                begin
                    ram_req.en   = 1'b1;
                    ram_req.addr = id_reg;
                    ret_next     = S_Q_DONE;
                    state_next   = S_Q_WAIT;
                end
                else if (r_reg > mid)
                begin
                    ram_req.en   = 1'b1;
                    ram_req.addr = lc;
                    id_next      = rc;
                    lo_next      = mid + PW'(1);
                    ret_next     = S_Q_RWALK;
                    state_next   = S_Q_WAIT;
                end
                else
                begin
                    id_next = lc;
                    hi_next = mid;
                end
            end

            S_Q_WAIT:
            begin
                if (rd_s > acc_reg)
                begin
                    acc_next = rd_s;
                end
                state_next = ret_reg;
            end

            S_Q_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = acc_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ret_reg      <= S_Q_DONE;
            clr_reg      <= '0;
            sp_reg       <= '0;
            size_reg     <= PW'(rmst_pkg::MAX_ITEMS);
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            clr_reg      <= clr_next;
            sp_reg       <= sp_next;
            size_reg     <= size_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        rid_reg     <= rid_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        rlo_reg     <= rlo_next;
        rhi_reg     <= rhi_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        pos_reg     <= pos_next;
        acc_reg     <= acc_next;
        val_reg     <= val_next;
    end

    // update path: node on the path and its sibling, one entry per level
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            node_stk[sp_reg] <= id_reg;
            sib_stk[sp_reg]  <= push_sib;
        end
    end

endmodule
`default_nettype wire

### test/tb_range_max_segment_tree.sv
`timescale 1ns / 1ps

module tb_range_max_segment_tree;

    import rmst_pkg::*;

    localparam int FIELD_MAX = 2047;   // all ones in an 11-bit field
    localparam int DRAIN_CYCLES = 80;  // outlasts the longest update

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [10:0]       cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [71:0]       s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;

    range_max_segment_tree dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // shadow copy of the tree, same preorder layout as the block
    logic signed [DATA_W-1:0] node_mem [NODE_COUNT];
    int unsigned              cur_size;
    logic signed [DATA_W-1:0] pending_max [$];

    int  errors;
    bit  gaps_on;
    bit  stalls_on;
    int  hold_len;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("range_max_segment_tree: mismatch");
        $finish;
    end

    function automatic logic signed [DATA_W-1:0] node_rd(input int unsigned id);
        return (id < NODE_COUNT) ? node_mem[id] : '0;
    endfunction

    function automatic logic signed [DATA_W-1:0] max2(input logic signed [DATA_W-1:0] a,
                                                      input logic signed [DATA_W-1:0] b);
        return (a >= b) ? a : b;
    endfunction

    function automatic void apply_update(input int unsigned pos,
                                         input logic signed [DATA_W-1:0] val);
        int unsigned path_id [16];
        int unsigned path_rc [16];
        int unsigned id;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned rc;
        int          depth;
        if (pos < 1 || pos > cur_size)
            return;
        id = 1;
        lo = 1;
        hi = cur_size;
        depth = 0;
        while (lo != hi)
        begin
            mid = (lo + hi) / 2;
            rc = id + 2 * (mid - lo + 1);
            path_id[depth] = id;
            path_rc[depth] = rc;
            depth++;
            if (pos <= mid)
            begin
                id = id + 1;
                hi = mid;
            end
            else
            begin
                id = rc;
                lo = mid + 1;
            end
        end
        if (id < NODE_COUNT)
            node_mem[id] = val;
        for (int k = depth - 1; k >= 0; k--)
            if (path_id[k] < NODE_COUNT)
                node_mem[path_id[k]] = max2(node_rd(path_id[k] + 1), node_rd(path_rc[k]));
    endfunction

    // walks the same nodes the block visits, so stale words after a resize count too
    function automatic logic signed [DATA_W-1:0] range_max(input int unsigned l,
                                                           input int unsigned r);
        int unsigned st_id [64];
        int unsigned st_lo [64];
        int unsigned st_hi [64];
        int          sp;
        int unsigned id;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned rc;
        bit          found;
        logic signed [DATA_W-1:0] best;
        if (l > r || l > cur_size || r < 1)
            return '0;
        st_id[0] = 1;
        st_lo[0] = 1;
        st_hi[0] = cur_size;
        sp = 1;
        found = 1'b0;
        best = '0;
        while (sp > 0)
        begin
            sp--;
            id = st_id[sp];
            lo = st_lo[sp];
            hi = st_hi[sp];
            if (l <= lo && hi <= r)
            begin
                best = found ? max2(best, node_rd(id)) : node_rd(id);
                found = 1'b1;
            end
            else
            begin
                mid = (lo + hi) / 2;
                rc = id + 2 * (mid - lo + 1);
                if (r > mid)
                begin
                    st_id[sp] = rc;
                    st_lo[sp] = mid + 1;
                    st_hi[sp] = hi;
                    sp++;
                end
                if (l <= mid)
                begin
                    st_id[sp] = id + 1;
                    st_lo[sp] = lo;
                    st_hi[sp] = mid;
                    sp++;
                end
            end
        end
        return best;
    endfunction

    // one input beat; the shadow tree advances when the beat is taken
    task automatic send_op(input logic op, input int unsigned pos, input logic [31:0] val,
                           input int unsigned l, input int unsigned r);
        int gap;
        gap = gaps_on ? $urandom_range(0, 13) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = op;
        s_tdata  = {7'd0, r[10:0], l[10:0], val, pos[10:0]};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        if (op == OP_UPDATE)
            apply_update(pos, val);
        else
            pending_max = {pending_max, range_max(l, r)};
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_max.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input int unsigned value);
        wait_idle();
        @(negedge clk);
        cfg_data  = value[10:0];
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cur_size = (value < 1) ? 1 : (value > MAX_ITEMS) ? MAX_ITEMS : value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3:    return $urandom_range(0, 16) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned rand_pos(input int unsigned n);
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return $urandom_range(n + 1, FIELD_MAX);
            default: return $urandom_range(1, n);
        endcase
    endfunction

    task automatic send_random_query(input int unsigned n);
        int unsigned l;
        int unsigned r;
        case ($urandom_range(0, 9))
            0:
            begin
                l = $urandom_range(0, FIELD_MAX);
                r = $urandom_range(0, FIELD_MAX);
            end
            1:
            begin
                l = $urandom_range(1, n);
                r = $urandom_range(0, l);
            end
            2:
            begin
                l = $urandom_range(1, n);
                r = $urandom_range(n, FIELD_MAX);
            end
            default:
            begin
                l = $urandom_range(1, n);
                r = $urandom_range(l, n);
            end
        endcase
        send_op(OP_QUERY, $urandom_range(0, FIELD_MAX), $urandom, l, r);
    endtask

    task automatic test_directed();
        send_op(OP_QUERY, 0, 0, 1, MAX_ITEMS);
        send_op(OP_UPDATE, 1, 32'h8000_0000, 0, 0);
        send_op(OP_UPDATE, MAX_ITEMS, 32'h7FFF_FFFF, FIELD_MAX, FIELD_MAX);
        send_op(OP_UPDATE, 0, 32'h1234_5678, 0, 0);
        send_op(OP_UPDATE, MAX_ITEMS + 1, 32'h7FFF_FFFF, 0, 0);
        send_op(OP_UPDATE, FIELD_MAX, 32'hFFFF_FFFF, 0, 0);
        send_op(OP_QUERY, 0, 0, 1, MAX_ITEMS);
        send_op(OP_QUERY, 0, 0, 1, 1);
        send_op(OP_QUERY, 0, 0, MAX_ITEMS, MAX_ITEMS);
        send_op(OP_QUERY, 0, 0, 5, 3);
        send_op(OP_QUERY, 0, 0, 0, 0);
        send_op(OP_QUERY, FIELD_MAX, 32'hFFFF_FFFF, 0, FIELD_MAX);
        send_op(OP_QUERY, 0, 0, MAX_ITEMS + 1, FIELD_MAX);
        send_op(OP_QUERY, 0, 0, FIELD_MAX, FIELD_MAX);
        send_op(OP_UPDATE, 512, 32'hFFFF_FFFF, 0, 0);
        send_op(OP_QUERY, 0, 0, 2, MAX_ITEMS - 1);
        send_op(OP_UPDATE, 600, 32'hFFFF_FFF0, 0, 0);
        send_op(OP_QUERY, 0, 0, 512, 600);
        send_op(OP_QUERY, 0, 0, 1, 600);
        send_op(OP_UPDATE, 1024, 32'h0000_0000, 0, 0);
        send_op(OP_QUERY, 0, 0, 513, MAX_ITEMS);
        wait_idle();
    endtask

    task automatic test_size_extremes();
        set_size(0);
        send_op(OP_QUERY, 0, 0, 1, 1);
        send_op(OP_UPDATE, 1, 32'h7FFF_FFFF, 0, 0);
        send_op(OP_UPDATE, 2, 32'h8000_0000, 0, 0);
        send_op(OP_QUERY, 0, 0, 0, FIELD_MAX);
        send_op(OP_QUERY, 0, 0, 2, 2);
        set_size(FIELD_MAX);
        send_op(OP_QUERY, 0, 0, 1, MAX_ITEMS);
        send_op(OP_QUERY, 0, 0, 300, 700);
        set_size(1);
        send_op(OP_QUERY, 0, 0, 1, FIELD_MAX);
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_size(MAX_ITEMS);
        gaps_on = 1'b0;
        hold_len = 500;
        for (int i = 0; i < 40; i++)
            send_random_query(MAX_ITEMS);
        wait_idle();
    endtask

    task automatic test_random(input int unsigned size, input int count,
                               input bit use_gaps, input bit use_stalls);
        set_size(size);
        gaps_on = use_gaps;
        stalls_on = use_stalls;
        for (int i = 0; i < count; i++)
            if ($urandom_range(0, 99) < 45)
                send_op(OP_UPDATE, rand_pos(cur_size), rand_value(),
                        $urandom_range(0, FIELD_MAX), $urandom_range(0, FIELD_MAX));
            else
                send_random_query(cur_size);
        wait_idle();
    endtask

    // result side: random stalls, plus a long hold-off when one is requested
    initial
    begin
        int wait_n;
        logic signed [DATA_W-1:0] want;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                wait_n = hold_len;
                hold_len = 0;
            end
            else
                wait_n = stalls_on ? $urandom_range(0, 13) : 0;
            if (wait_n > 0)
            begin
                m_tready = 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pending_max.size() == 0)
            begin
                errors++;
                $display("%0t: max_value expected none got %0d", $time, $signed(m_tdata));
            end
            else
            begin
                want = pending_max.pop_front();
                if (m_tdata !== want)
                begin
                    errors++;
                    $display("%0t: max_value expected %0d got %0d",
                             $time, want, $signed(m_tdata));
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_UPDATE;
        m_tready  = 1'b0;
        errors    = 0;
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        hold_len  = 0;
        cur_size  = MAX_ITEMS;
        foreach (node_mem[i])
            node_mem[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_size_extremes();
        test_backpressure();
        test_random(MAX_ITEMS, 220, 1'b1, 1'b1);
        test_random(1, 40, 1'b0, 1'b1);
        test_random(2, 40, 1'b1, 1'b0);
        test_random(3, 60, 1'b1, 1'b1);
        test_random(7, 80, 1'b0, 1'b0);
        test_random(100, 140, 1'b1, 1'b1);
        test_random(1000, 140, 1'b1, 1'b0);
        test_random(513, 100, 1'b0, 1'b1);
        test_random(FIELD_MAX, 80, 1'b1, 1'b1);

        if (errors == 0)
            $display("range_max_segment_tree: match");
        else
            $display("range_max_segment_tree: mismatch");
        $finish;
    end

endmodule

### files.f
sv/rmst_pkg.sv
sv/rmst_node_ram.sv
sv/range_max_segment_tree.sv
test/tb_range_max_segment_tree.sv
